// File: rtl/core/repeat_offender_blacklist_table_macros.svh
// Assertion macros shared by the blacklist table RTL.
`ifndef REPEAT_OFFENDER_BLACKLIST_TABLE_MACROS_SVH
`define REPEAT_OFFENDER_BLACKLIST_TABLE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, held off during reset.
`define ROBT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("robt: implication check failed");
// Next-cycle implication, held off during reset.
`define ROBT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("robt: next-cycle check failed");
`else
`define ROBT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ROBT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/robt_pkg.sv
// Shared types and constants of the blacklist table.
`default_nettype none
package robt_pkg;

	localparam int CNT_W   = 8;
	localparam int OP_W    = 2;
	localparam int IN_W    = 24;  // op + key, padded to bytes
	localparam int OUT_W   = 16;  // five result fields, padded to bytes
	localparam int CFG_W   = 8;

	localparam logic [CNT_W-1:0] LIMIT_RESET = 8'd5;
	localparam logic [CNT_W-1:0] CNT_MAX     = 8'hFF;

	localparam logic [OP_W-1:0] OP_CHECK = 2'd0;
	localparam logic [OP_W-1:0] OP_OPEN  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLOSE = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic clear;   // clearing sweep step
		logic load;    // capture input beat, restart scan
		logic scan;    // read both stores at the scan index
		logic update;  // apply writes, fill result register
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_last;  // scan index at last entry
		logic out_free;   // result register can take a new result
	} dp_stat_t;

endpackage
`default_nettype wire

// File: rtl/core/robt_ctrl.sv
// Sequencer for clearing sweep, table scan and update.
`default_nettype none
module robt_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	output logic                 s_tready,
	input  robt_pkg::dp_stat_t   stat,
	output robt_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_FLUSH  = 5'b01000,
		ST_UPDATE = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (stat.scan_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (stat.scan_last) state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				// last read compares here; wait for the result register
				if (stat.out_free) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready   = (state_q == ST_IDLE);
	assign cmd.clear  = (state_q == ST_CLEAR);
	assign cmd.load   = s_tvalid && (state_q == ST_IDLE);
	assign cmd.scan   = (state_q == ST_SCAN);
	assign cmd.update = (state_q == ST_UPDATE);

endmodule
`default_nettype wire

// File: rtl/core/robt_dpath.sv
// Stores, scan compare, update logic and result register.
`default_nettype none
`include "repeat_offender_blacklist_table_macros.svh"
module robt_dpath #(
	parameter int TRACK_ENTRIES = 16,
	parameter int BAN_ENTRIES   = 16,
	parameter int KEY_BITS      = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  robt_pkg::ctrl_cmd_t          cmd,
	output robt_pkg::dp_stat_t           stat,
	input  wire [robt_pkg::OP_W-1:0]     in_op,
	input  wire [15:0]                   in_key,
	input  wire                          cfg_we,
	input  wire [robt_pkg::CFG_W-1:0]    cfg_wdata,
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [robt_pkg::OUT_W-1:0]   m_tdata
);

	localparam int SCAN_LEN = (TRACK_ENTRIES > BAN_ENTRIES) ? TRACK_ENTRIES : BAN_ENTRIES;
	localparam int IDX_W    = (SCAN_LEN > 1) ? $clog2(SCAN_LEN) : 1;
	localparam int TA_W     = (TRACK_ENTRIES > 1) ? $clog2(TRACK_ENTRIES) : 1;
	localparam int BA_W     = (BAN_ENTRIES > 1) ? $clog2(BAN_ENTRIES) : 1;
	localparam int CW       = robt_pkg::CNT_W;
	localparam int TW       = 1 + CW + KEY_BITS;  // {valid, count, key}
	localparam int BW       = 1 + KEY_BITS;       // {valid, key}
	localparam int PAD_W    = robt_pkg::OUT_W - (CW + 4);

	// stores; reset content comes from the clearing sweep
	logic [TW-1:0] track_mem [TRACK_ENTRIES];
	logic [BW-1:0] ban_mem   [BAN_ENTRIES];

	logic [IDX_W-1:0]          idx_q;
	logic [CW-1:0]             limit_q;
	logic [robt_pkg::OP_W-1:0] op_q;
	logic [KEY_BITS-1:0]       key_q;
	logic [31:0]               key_wide;

	logic          trk_in_rng, ban_in_rng;
	logic          trk_rv_s1, ban_rv_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [TW-1:0] trk_rd_s1;
	logic [BW-1:0] ban_rd_s1;

	logic            hit_q, free_q, ban_hit_q, ban_free_q;
	logic [TA_W-1:0] hit_slot_q, free_slot_q;
	logic [BA_W-1:0] ban_free_slot_q;
	logic [CW-1:0]   cnt_q;

	logic            trk_we, ban_we;
	logic [TA_W-1:0] trk_wa;
	logic [TW-1:0]   trk_wd;
	logic [BW-1:0]   ban_wd;
	logic [CW-1:0]   cnt_inc, cnt_dec, res_cnt;
	logic            res_prom, res_full;

	logic            m_tvalid_q;
	logic            out_bl_q, out_prom_q, out_found_q, out_full_q;
	logic [CW-1:0]   out_cnt_q;

	assign key_wide   = {16'd0, in_key};
	assign trk_in_rng = (32'(idx_q) < 32'(TRACK_ENTRIES));
	assign ban_in_rng = (32'(idx_q) < 32'(BAN_ENTRIES));

	assign stat.scan_last = (idx_q == IDX_W'(SCAN_LEN - 1));
	assign stat.out_free  = !m_tvalid_q || m_tready;

	// scan index, shared by the clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load) begin
			idx_q <= '0;
		end else if (cmd.clear || cmd.scan) begin
			idx_q <= stat.scan_last ? '0 : idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= robt_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= in_op;
			key_q <= key_wide[KEY_BITS-1:0];
		end
	end

	// stores: registered read during scan, one write per cycle
	always_ff @(posedge clk) begin
		if (cmd.scan && trk_in_rng) begin
			trk_rd_s1 <= track_mem[idx_q[TA_W-1:0]];
		end
		if (cmd.clear) begin
			if (trk_in_rng) track_mem[idx_q[TA_W-1:0]] <= '0;
		end else if (cmd.update && trk_we) begin
			track_mem[trk_wa] <= trk_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan && ban_in_rng) begin
			ban_rd_s1 <= ban_mem[idx_q[BA_W-1:0]];
		end
		if (cmd.clear) begin
			if (ban_in_rng) ban_mem[idx_q[BA_W-1:0]] <= '0;
		end else if (cmd.update && ban_we) begin
			ban_mem[ban_free_slot_q] <= ban_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trk_rv_s1 <= 1'b0;
			ban_rv_s1 <= 1'b0;
		end else begin
			trk_rv_s1 <= cmd.scan && trk_in_rng;
			ban_rv_s1 <= cmd.scan && ban_in_rng;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
	end

	// compare stage: first match, lowest free slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			ban_hit_q  <= 1'b0;
			ban_free_q <= 1'b0;
		end else if (cmd.load) begin
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			ban_hit_q  <= 1'b0;
			ban_free_q <= 1'b0;
		end else begin
			if (trk_rv_s1) begin
				if (trk_rd_s1[TW-1] && (trk_rd_s1[KEY_BITS-1:0] == key_q) && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (!trk_rd_s1[TW-1] && !free_q) begin
					free_q <= 1'b1;
				end
			end
			if (ban_rv_s1) begin
				if (ban_rd_s1[BW-1] && (ban_rd_s1[KEY_BITS-1:0] == key_q)) begin
					ban_hit_q <= 1'b1;
				end
				if (!ban_rd_s1[BW-1] && !ban_free_q) begin
					ban_free_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (trk_rv_s1) begin
			if (trk_rd_s1[TW-1] && (trk_rd_s1[KEY_BITS-1:0] == key_q) && !hit_q) begin
				hit_slot_q <= idx_s1[TA_W-1:0];
				cnt_q      <= trk_rd_s1[TW-2 -: CW];
			end
			if (!trk_rd_s1[TW-1] && !free_q) begin
				free_slot_q <= idx_s1[TA_W-1:0];
			end
		end
		if (ban_rv_s1 && !ban_rd_s1[BW-1] && !ban_free_q) begin
			ban_free_slot_q <= idx_s1[BA_W-1:0];
		end
	end

	assign cnt_inc = (cnt_q == robt_pkg::CNT_MAX) ? cnt_q : cnt_q + CW'(1);
	assign cnt_dec = cnt_q - CW'(1);
	assign ban_wd  = {1'b1, key_q};

	// update decision
	always_comb begin
		trk_we   = 1'b0;
		trk_wa   = hit_slot_q;
		trk_wd   = {1'b1, cnt_inc, key_q};
		ban_we   = 1'b0;
		res_prom = 1'b0;
		res_full = 1'b0;
		res_cnt  = '0;
		case (op_q)
			robt_pkg::OP_OPEN: begin
				if (hit_q) begin
					trk_we  = 1'b1;
					res_cnt = cnt_inc;
					if (cnt_inc > limit_q) begin
						if (ban_hit_q || ban_free_q) begin
							ban_we   = !ban_hit_q;
							trk_wd   = '0;
							res_prom = 1'b1;
							res_cnt  = '0;
						end else begin
							res_full = 1'b1;  // keep the count, retry on a later open
						end
					end
				end else if (free_q) begin
					trk_we = 1'b1;
					trk_wa = free_slot_q;
					trk_wd = {1'b1, {CW{1'b0}}, key_q};
				end else begin
					res_full = 1'b1;
				end
			end
			robt_pkg::OP_CLOSE: begin
				if (hit_q) begin
					trk_we = 1'b1;
					if (cnt_q == '0) begin
						trk_wd = '0;
					end else begin
						trk_wd  = {1'b1, cnt_dec, key_q};
						res_cnt = cnt_dec;
					end
				end
			end
			default: begin
				if (hit_q) res_cnt = cnt_q;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.update) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			out_bl_q    <= ban_hit_q || ban_we;
			out_prom_q  <= res_prom;
			out_found_q <= hit_q;
			out_cnt_q   <= res_cnt;
			out_full_q  <= res_full;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_full_q, out_cnt_q, out_found_q, out_prom_q, out_bl_q};

	`ROBT_ASSERT_IMP(a_prom_bans, clk, arst_n, m_tvalid_q && out_prom_q, out_bl_q && out_found_q && !out_full_q && (out_cnt_q == '0))
	`ROBT_ASSERT_IMP(a_miss_zero, clk, arst_n, m_tvalid_q && !out_found_q, (out_cnt_q == '0) && !out_prom_q)
	`ROBT_ASSERT_NXT(a_upd_out, clk, arst_n, cmd.update, m_tvalid_q)

endmodule
`default_nettype wire

// File: rtl/core/repeat_offender_blacklist_table.sv
// Top level of the repeat-offender blacklist table.
`default_nettype none
// Repeat-offender blacklist table. Each input beat carries an op (check, open,
// close) and a client key; each one yields exactly one result beat. Opens
// count per key in a counter table; once a count goes above the limit
// register the key moves to the blacklist, if that has a free slot or
// already holds the key. Both stores are scanned one entry per cycle
// through a single read port each; an item goes through an accept step,
// the scan, a compare step for the last read, which waits for the result
// register to be free, and an update step. One item is worked at a time;
// s_tready is high only between items, and a new item can be accepted
// while the previous result beat is still waiting on m_tready. After reset
// a clearing sweep over max(TRACK_ENTRIES, BAN_ENTRIES) entries empties
// both stores; s_tready stays low for that time, while limit writes on the
// cfg channel are taken at any time (cfg_ready is always high). Change
// limit only while no item is in flight.
module repeat_offender_blacklist_table #(
	parameter int TRACK_ENTRIES = 16,  // counter table slots, 1..1024
	parameter int BAN_ENTRIES   = 16,  // blacklist slots, 1..1024
	parameter int KEY_BITS      = 16   // key bits compared and stored, 1..32
) (
	input  wire                          clk,
	input  wire                          arst_n,
	// input beats
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire [robt_pkg::IN_W-1:0]     s_tdata,   // [1:0] op, [17:2] key, rest zero
	// result beats
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [robt_pkg::OUT_W-1:0]   m_tdata,   // [0] is_blacklisted, [1] promoted,
	                                                // [2] found, [10:3] count_value,
	                                                // [11] table_full, rest zero
	// limit register writes
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire [robt_pkg::CFG_W-1:0]    cfg_data   // limit
);

	robt_pkg::ctrl_cmd_t cmd;
	robt_pkg::dp_stat_t  stat;

	assign cfg_ready = 1'b1;

	// sequencer: clear sweep, scan, compare flush, update
	robt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// stores, compare, update rules and the result register
	robt_dpath #(
		.TRACK_ENTRIES (TRACK_ENTRIES),
		.BAN_ENTRIES   (BAN_ENTRIES),
		.KEY_BITS      (KEY_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_op     (s_tdata[robt_pkg::OP_W-1:0]),
		.in_key    (s_tdata[robt_pkg::OP_W +: 16]),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_wdata (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for the repeat-offender blacklist table.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TRACK_N = 16;
	localparam int BAN_N   = 16;
	localparam int KEY_W   = 16;

	// op code 3 is not used by software; the block treats it as a check
	localparam logic [robt_pkg::OP_W-1:0] OP_SPARE = 2'd3;

	typedef struct packed {
		logic [KEY_W-1:0]          key;
		logic [robt_pkg::OP_W-1:0] op;
	} conn_evt_t;

	// result beat layout, lowest bit last
	typedef struct packed {
		logic                       table_full;
		logic [robt_pkg::CNT_W-1:0] count_value;
		logic                       found;
		logic                       promoted;
		logic                       is_blacklisted;
	} verdict_t;

	typedef enum {RX_FREE, RX_CHOPPY, RX_BURSTY} rx_style_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                        s_tvalid = 1'b0;
	wire                         s_tready;
	logic [robt_pkg::IN_W-1:0]   s_tdata = '0;   // [1:0] op, [17:2] key, rest zero
	wire                         m_tvalid;
	logic                        m_tready = 1'b0;
	wire  [robt_pkg::OUT_W-1:0]  m_tdata;        // [0] is_blacklisted, [1] promoted,
	                                             // [2] found, [10:3] count_value,
	                                             // [11] table_full
	logic                        cfg_valid = 1'b0;
	wire                         cfg_ready;
	logic [robt_pkg::CFG_W-1:0]  cfg_data = '0;

	repeat_offender_blacklist_table u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the two stores and the limit register, as the block
	// should hold them after every accepted beat.
	logic [KEY_W-1:0]           tally_key [TRACK_N];
	logic [robt_pkg::CNT_W-1:0] tally_cnt [TRACK_N];
	logic                       tally_live[TRACK_N];
	logic [KEY_W-1:0]           ban_key   [BAN_N];
	logic                       ban_live  [BAN_N];
	logic [robt_pkg::CNT_W-1:0] limit_q = robt_pkg::LIMIT_RESET;

	conn_evt_t        events_pending[$];  // beats not yet taken by the block
	verdict_t         verdicts_due[$];    // results owed by the block, oldest first
	logic [KEY_W-1:0] key_pool[$];        // keys the current phase keeps hitting

	int        accepted_cnt = 0;
	int        fail_cnt = 0;
	bit        tx_idle = 1'b0;
	rx_style_t rx_mode = RX_FREE;
	logic      long_hold = 1'b0;

	initial begin
		for (int i = 0; i < TRACK_N; i++) begin
			tally_key[i] = '0;
			tally_cnt[i] = '0;
			tally_live[i] = 1'b0;
		end
		for (int i = 0; i < BAN_N; i++) begin
			ban_key[i] = '0;
			ban_live[i] = 1'b0;
		end
	end

	function automatic bit is_banned(logic [KEY_W-1:0] k);
		for (int i = 0; i < BAN_N; i++)
			if (ban_live[i] && ban_key[i] == k)
				return 1'b1;
		return 1'b0;
	endfunction

	// Applies one connection event to the shadow stores and returns the
	// result beat the block owes for it.
	function automatic verdict_t screen_event(conn_evt_t ev);
		verdict_t                   v;
		int                         slot;
		int                         hole;
		int                         ban_hole;
		logic [robt_pkg::CNT_W-1:0] c;
		v = '0;
		slot = -1;
		hole = -1;
		ban_hole = -1;
		// scan downward so the lowest matching / free slot wins
		for (int i = TRACK_N - 1; i >= 0; i--) begin
			if (tally_live[i] && tally_key[i] == ev.key)
				slot = i;
			if (!tally_live[i])
				hole = i;
		end
		v.found = (slot >= 0);
		case (ev.op)
			robt_pkg::OP_OPEN: begin
				if (slot >= 0) begin
					c = (tally_cnt[slot] == robt_pkg::CNT_MAX) ? robt_pkg::CNT_MAX :
						tally_cnt[slot] + 8'd1;
					tally_cnt[slot] = c;
					v.count_value = c;
					if (c > limit_q) begin
						if (is_banned(ev.key)) begin
							// already listed: leaves the counter table only
							tally_live[slot] = 1'b0;
							v.promoted = 1'b1;
							v.count_value = '0;
						end else begin
							for (int i = BAN_N - 1; i >= 0; i--)
								if (!ban_live[i])
									ban_hole = i;
							if (ban_hole >= 0) begin
								ban_key[ban_hole] = ev.key;
								ban_live[ban_hole] = 1'b1;
								tally_live[slot] = 1'b0;
								v.promoted = 1'b1;
								v.count_value = '0;
							end else begin
								// blacklist full: key keeps its count, retried next open
								v.table_full = 1'b1;
							end
						end
					end
				end else if (hole >= 0) begin
					tally_key[hole] = ev.key;
					tally_cnt[hole] = '0;
					tally_live[hole] = 1'b1;
				end else begin
					v.table_full = 1'b1;
				end
			end
			robt_pkg::OP_CLOSE: begin
				if (slot >= 0) begin
					if (tally_cnt[slot] == '0) begin
						tally_live[slot] = 1'b0;
					end else begin
						tally_cnt[slot] = tally_cnt[slot] - 8'd1;
						v.count_value = tally_cnt[slot];
					end
				end
			end
			default: begin
				// check and the spare code only report
				if (slot >= 0)
					v.count_value = tally_cnt[slot];
			end
		endcase
		v.is_blacklisted = is_banned(ev.key);
		return v;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			fail_cnt++;
			if (fail_cnt <= 200)
				$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	// Sender: bursts of random length, random gaps between them when
	// tx_idle is set. valid stays up until the beat is taken.
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;

	always @(posedge clk) begin
		conn_evt_t ev;
		logic      fire;
		logic      take;
		fire = s_tvalid && s_tready;
		if (fire) begin
			ev = events_pending.pop_front();
			verdicts_due.push_back(screen_event(ev));
			accepted_cnt++;
		end
		if (!s_tvalid || fire) begin
			take = 1'b0;
			if (gap_left != 0) begin
				gap_left--;
			end else if (events_pending.size() != 0) begin
				take = 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 6);
					// gaps up to about two item times so they land on every scan step
					if (tx_idle && $urandom_range(0, 3) != 0)
						gap_left = $urandom_range(1, 45);
				end else begin
					burst_left--;
				end
			end
			s_tvalid <= take;
			if (take)
				s_tdata <= {6'b0, events_pending[0].key, events_pending[0].op};
		end
	end

	// Receiver: checks each result beat against the oldest expectation and
	// drives its own stall pattern on m_tready.
	int unsigned stall_left = 0;

	always @(posedge clk) begin
		verdict_t got;
		verdict_t want;
		if (m_tvalid && m_tready) begin
			got = verdict_t'(m_tdata[11:0]);
			if (verdicts_due.size() == 0) begin
				fail_cnt++;
				if (fail_cnt <= 200)
					$display("%0t ns: result beat with nothing expected, expected none, actual %h",
						$time, m_tdata);
			end else begin
				want = verdicts_due.pop_front();
				check_field("is_blacklisted", 32'(want.is_blacklisted),
					32'(got.is_blacklisted));
				check_field("promoted", 32'(want.promoted), 32'(got.promoted));
				check_field("found", 32'(want.found), 32'(got.found));
				check_field("count_value", 32'(want.count_value), 32'(got.count_value));
				check_field("table_full", 32'(want.table_full), 32'(got.table_full));
			end
		end
		if (long_hold) begin
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_FREE: begin
					m_tready <= 1'b1;
				end
				RX_CHOPPY: begin
					m_tready <= ($urandom_range(0, 3) != 0);
				end
				default: begin
					if (stall_left != 0) begin
						stall_left--;
						m_tready <= 1'b0;
					end else if ($urandom_range(0, 11) == 0) begin
						stall_left = $urandom_range(1, 40);
						m_tready <= 1'b0;
					end else begin
						m_tready <= 1'b1;
					end
				end
			endcase
		end
	end

	// One long receiver hold-off while the sender keeps offering beats:
	// the result register fills, then the block must drop s_tready.
	initial begin
		wait (accepted_cnt >= 90);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (400) @(posedge clk);
		long_hold <= 1'b0;
	end

	// Run limit, far above the slowest legal run.
	initial begin
		#10_000_000;
		$display("FAILURE");
		$finish;
	end

	// Waits at a clock edge until every queued beat was taken and answered.
	task automatic drain();
		do @(posedge clk);
		while (events_pending.size() != 0 || verdicts_due.size() != 0);
	endtask

	// Called at a clock edge while nothing is in flight.
	task automatic set_limit(input logic [robt_pkg::CFG_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		limit_q = v;
	endtask

	function automatic conn_evt_t pick_event();
		conn_evt_t   ev;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			ev.op = robt_pkg::OP_OPEN;
		else if (r < 75)
			ev.op = robt_pkg::OP_CLOSE;
		else if (r < 95)
			ev.op = robt_pkg::OP_CHECK;
		else
			ev.op = OP_SPARE;
		// mostly pool keys so counts climb; some keys from the whole range
		if ($urandom_range(0, 9) == 0)
			ev.key = KEY_W'($urandom_range(0, 16'hFFFF));
		else
			ev.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
		return ev;
	endfunction

	task automatic push_evt(input logic [robt_pkg::OP_W-1:0] op, input logic [KEY_W-1:0] key);
		conn_evt_t ev;
		ev.op = op;
		ev.key = key;
		events_pending.push_back(ev);
	endtask

	// One random phase: new limit, new idling styles, new key pool. With
	// hot set, most beats open one key that sits in the counter table so
	// its count climbs to the ceiling.
	task automatic run_phase(input logic [robt_pkg::CFG_W-1:0] lim, input int n,
			input int pool_n, input bit tx_gaps, input rx_style_t rx, input bit hot);
		conn_evt_t        ev;
		logic [KEY_W-1:0] hot_key;
		drain();
		set_limit(lim);
		@(negedge clk);
		tx_idle = tx_gaps;
		rx_mode = rx;
		key_pool.delete();
		repeat (pool_n) key_pool.push_back(KEY_W'($urandom_range(0, 16'hFFFF)));
		hot_key = KEY_W'($urandom_range(0, 16'hFFFF));
		for (int i = 0; i < TRACK_N; i++)
			if (tally_live[i])
				hot_key = tally_key[i];
		for (int i = 0; i < n; i++) begin
			if (hot && $urandom_range(0, 9) != 0) begin
				ev.op = robt_pkg::OP_OPEN;
				ev.key = hot_key;
			end else begin
				ev = pick_event();
			end
			events_pending.push_back(ev);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed beats at the reset limit of 5, no idling on either side.
		tx_idle = 1'b0;
		rx_mode = RX_FREE;
		push_evt(robt_pkg::OP_CHECK, 16'h0000);     // empty stores
		push_evt(OP_SPARE, 16'hFFFF);               // spare code acts as a check
		push_evt(robt_pkg::OP_CLOSE, 16'hFFFF);     // close on an unknown key
		push_evt(robt_pkg::OP_OPEN, 16'h0000);      // insert with count 0
		repeat (6) push_evt(robt_pkg::OP_OPEN, 16'h0000);  // counts 1..6, moves on 6
		push_evt(robt_pkg::OP_CHECK, 16'h0000);     // listed, gone from counter table
		push_evt(robt_pkg::OP_OPEN, 16'h0000);      // open on a listed key inserts again
		push_evt(robt_pkg::OP_OPEN, 16'hFFFF);
		push_evt(robt_pkg::OP_OPEN, 16'hFFFF);
		push_evt(robt_pkg::OP_CLOSE, 16'hFFFF);     // down to 0, stays
		push_evt(OP_SPARE, 16'hFFFF);
		push_evt(robt_pkg::OP_CLOSE, 16'hFFFF);     // close at count 0 removes
		push_evt(robt_pkg::OP_CHECK, 16'hFFFF);
		push_evt(robt_pkg::OP_OPEN, 16'hAAAA);
		push_evt(robt_pkg::OP_OPEN, 16'h5555);
		push_evt(robt_pkg::OP_CHECK, 16'hAAAA);
		push_evt(robt_pkg::OP_OPEN, 16'h5555);
		push_evt(robt_pkg::OP_CLOSE, 16'h5555);
		push_evt(robt_pkg::OP_CHECK, 16'h5555);

		// Random phases; the blacklist is never emptied, so phases with few
		// promotions come first and the zero limit last.
		run_phase(8'd254, 180, 24, 1'b1, RX_BURSTY, 1'b0);  // counter table overflows
		run_phase(8'd255, 300, 12, 1'b1, RX_CHOPPY, 1'b1);  // count ceiling, never listed
		run_phase(8'd3, 200, 30, 1'b0, RX_CHOPPY, 1'b0);
		run_phase(8'($urandom_range(1, 253)), 200, 20, 1'b1, RX_BURSTY, 1'b0);
		run_phase(8'd0, 170, 40, 1'b1, RX_FREE, 1'b0);      // blacklist fills up

		drain();
		repeat (40) @(posedge clk);
		if (fail_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
